/* design/csp_pkg.sv */
// Shared constants and types for the cross stencil probability map.
package csp_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // circular pixel window: two rows plus two entries
   localparam int WIN_DEPTH = 2 * MAX_WIDTH + 2;
   localparam int ADDR_W    = $clog2(WIN_DEPTH);

   localparam int DIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int CFG_W  = 11;
   localparam int PIX_W  = 8;
   localparam int PROB_W = 11;

   localparam logic [CFG_W-1:0] FRAME_DIM_RESET = CFG_W'(1024);

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // transaction kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // which taps are real and which fall back to the centre
   typedef struct packed {
      logic             use_left;
      logic             use_right;
      logic             use_up;
      logic             down_pixel;
      logic [PIX_W-1:0] down_val;
      logic             last;
   } tap_ctrl_type;

   typedef struct packed {
      logic [ADDR_W-1:0] centre;
      logic [ADDR_W-1:0] left;
      logic [ADDR_W-1:0] right;
      logic [ADDR_W-1:0] up;
   } rd_addr_type;

endpackage

/* design/csp_ram.sv */
// Generic RAM: one write port, two registered read ports.
module csp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* design/csp_seq.sv */
// Raster position tracking, window addressing and tail release.
module csp_seq import csp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              req_type,
   input  logic [PIX_W-1:0]  pixel_gray,
   input  logic [CFG_W-1:0]  frame_width,
   input  logic [CFG_W-1:0]  frame_height,
   output logic              has_result,
   output tap_ctrl_type      ctrl,
   output rd_addr_type       rd_addr,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [PIX_W-1:0]  wr_data
);

   function automatic logic [ADDR_W-1:0] wrap_sub(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] d);
      logic [ADDR_W:0] low;
      low = {1'b0, a} + (ADDR_W+1)'(WIN_DEPTH) - {1'b0, d};
      if (a >= d) return a - d;
      return low[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(WIN_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
      return (a == '0) ? ADDR_W'(WIN_DEPTH - 1) : a - 1'b1;
   endfunction

   logic [ADDR_W-1:0] wr_addr_ff,  wr_addr_in;
   logic [COL_W-1:0]  col_ff,      col_in;
   logic [ROW_W-1:0]  row_ff,      row_in;
   logic [DIM_W-1:0]  cur_w_ff,    cur_w_in;
   logic [HGT_W-1:0]  cur_h_ff,    cur_h_in;
   logic [DIM_W-1:0]  pending_ff,  pending_in;
   logic [ADDR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [COL_W-1:0]  tail_col_ff, tail_col_in;
   logic [DIM_W-1:0]  tail_w_ff,   tail_w_in;
   logic [HGT_W-1:0]  tail_h_ff,   tail_h_in;

   logic              is_pixel;
   logic              frame_start;
   logic [DIM_W-1:0]  width_cfg;
   logic [HGT_W-1:0]  height_cfg;
   logic [DIM_W-1:0]  eff_w;
   logic [HGT_W-1:0]  eff_h;
   logic              row_case;
   logic              tail_case;
   logic              row_end;
   logic              frame_end;
   logic [ADDR_W-1:0] centre_addr;
   logic [PIX_W-1:0]  inv_pixel;

   always_comb begin
      // effective geometry: zero means one, oversize saturates
      if (frame_width == '0) begin
         width_cfg = DIM_W'(1);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         width_cfg = DIM_W'(MAX_WIDTH);
      end else begin
         width_cfg = DIM_W'(frame_width);
      end
      if (frame_height == '0) begin
         height_cfg = HGT_W'(1);
      end else if (32'(frame_height) > MAX_HEIGHT) begin
         height_cfg = HGT_W'(MAX_HEIGHT);
      end else begin
         height_cfg = HGT_W'(frame_height);
      end
   end

   assign is_pixel    = (req_type == REQ_PIXEL);
   assign frame_start = (col_ff == '0) && (row_ff == '0);
   assign eff_w       = frame_start ? width_cfg  : cur_w_ff;
   assign eff_h       = frame_start ? height_cfg : cur_h_ff;
   assign row_case    = is_pixel && (row_ff != '0);
   assign tail_case   = !row_case && (pending_ff != '0);
   assign has_result  = row_case || tail_case;
   assign row_end     = (DIM_W'(col_ff) + DIM_W'(1)) == eff_w;
   assign frame_end   = row_end && ((HGT_W'(row_ff) + HGT_W'(1)) == eff_h);
   assign inv_pixel   = ~pixel_gray;

   // read addresses: centre row is one line back, or the held tail row
   always_comb begin
      centre_addr = row_case ? wrap_sub(wr_addr_ff, ADDR_W'(cur_w_ff)) : tail_ptr_ff;
      rd_addr.centre = centre_addr;
      rd_addr.left   = wrap_dec(centre_addr);
      rd_addr.right  = wrap_inc(centre_addr);
      rd_addr.up     = row_case ? wrap_sub(wr_addr_ff, ADDR_W'({cur_w_ff, 1'b0}))
                                : wrap_sub(tail_ptr_ff, ADDR_W'(tail_w_ff));
   end

   always_comb begin
      if (row_case) begin
         ctrl.use_left   = (col_ff != '0);
         ctrl.use_right  = (DIM_W'(col_ff) + DIM_W'(1)) < cur_w_ff;
         ctrl.use_up     = (row_ff != ROW_W'(1));
         ctrl.down_pixel = 1'b1;
         ctrl.last       = 1'b0;
      end else begin
         // final row of the previous frame: no lower neighbour
         ctrl.use_left   = (tail_col_ff != '0);
         ctrl.use_right  = (DIM_W'(tail_col_ff) + DIM_W'(1)) < tail_w_ff;
         ctrl.use_up     = (tail_h_ff != HGT_W'(1));
         ctrl.down_pixel = 1'b0;
         ctrl.last       = (pending_ff == DIM_W'(1));
      end
      ctrl.down_val = inv_pixel;
   end

   assign wr_en   = accept && is_pixel;
   assign wr_addr = wr_addr_ff;
   assign wr_data = inv_pixel;

   always_comb begin
      wr_addr_in  = wr_addr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cur_w_in    = cur_w_ff;
      cur_h_in    = cur_h_ff;
      pending_in  = pending_ff;
      tail_ptr_in = tail_ptr_ff;
      tail_col_in = tail_col_ff;
      tail_w_in   = tail_w_ff;
      tail_h_in   = tail_h_ff;
      if (accept) begin
         if (row_case) begin
            pending_in = '0;
         end else if (tail_case) begin
            tail_ptr_in = wrap_inc(tail_ptr_ff);
            tail_col_in = tail_col_ff + 1'b1;
            pending_in  = pending_ff - 1'b1;
         end
         if (is_pixel) begin
            cur_w_in   = eff_w;
            cur_h_in   = eff_h;
            wr_addr_in = wrap_inc(wr_addr_ff);
            if (row_end) begin
               col_in = '0;
               if (frame_end) begin
                  row_in      = '0;
                  tail_ptr_in = wrap_sub(wr_addr_ff, ADDR_W'(eff_w - 1'b1));
                  tail_col_in = '0;
                  tail_w_in   = eff_w;
                  tail_h_in   = eff_h;
                  pending_in  = eff_w;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_addr_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         cur_w_ff    <= DIM_W'(1);
         cur_h_ff    <= HGT_W'(1);
         pending_ff  <= '0;
         tail_ptr_ff <= '0;
         tail_col_ff <= '0;
         tail_w_ff   <= DIM_W'(1);
         tail_h_ff   <= HGT_W'(1);
      end else begin
         wr_addr_ff  <= wr_addr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         cur_w_ff    <= cur_w_in;
         cur_h_ff    <= cur_h_in;
         pending_ff  <= pending_in;
         tail_ptr_ff <= tail_ptr_in;
         tail_col_ff <= tail_col_in;
         tail_w_ff   <= tail_w_in;
         tail_h_ff   <= tail_h_in;
      end
   end

endmodule

/* design/csp_sum.sv */
// Five-point cross sum and result register.
module csp_sum import csp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              s1_valid,
   input  tap_ctrl_type      ctrl,
   input  logic [PIX_W-1:0]  centre,
   input  logic [PIX_W-1:0]  left,
   input  logic [PIX_W-1:0]  right,
   input  logic [PIX_W-1:0]  up,
   input  logic              rsp_ready,
   output logic              load_ok,
   output logic              rsp_valid,
   output logic [PROB_W-1:0] prob,
   output logic              last
);

   logic              rsp_v_ff,  rsp_v_in;
   logic [PROB_W-1:0] prob_ff,   prob_in;
   logic              last_ff;
   logic [PIX_W-1:0]  l_sel, r_sel, u_sel, d_sel;

   assign load_ok = !rsp_v_ff || rsp_ready;

   always_comb begin
      l_sel   = ctrl.use_left   ? left          : centre;
      r_sel   = ctrl.use_right  ? right         : centre;
      u_sel   = ctrl.use_up     ? up            : centre;
      d_sel   = ctrl.down_pixel ? ctrl.down_val : centre;
      // 8 * 255 = 2040, never wraps
      prob_in = PROB_W'({centre, 2'b00}) + PROB_W'(l_sel) + PROB_W'(r_sel)
              + PROB_W'(u_sel) + PROB_W'(d_sel);
      rsp_v_in = load_ok ? s1_valid : rsp_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && s1_valid) begin
         prob_ff <= prob_in;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign prob      = prob_ff;
   assign last      = last_ff;

endmodule

/* design/cross_stencil_probability_map.sv */
// Top level of the cross stencil probability map.
//
// Gray pixels enter in raster order, one transaction per clock while the
// result stream does not stall; each is stored inverted (255 minus gray)
// in a circular window of 2*MAX_WIDTH+2 entries. Every pixel yields
// 4*centre + left + right + up + down on inverted values (a neighbour off
// the frame takes the centre value), an exact number in 0..2040 read as a
// probability of value/2040. A result is issued when its lower neighbour
// arrives, so output lags input by about one line; the last row of a frame
// is released by drain transactions (req_tuser = 1) or by the first row of
// the next frame. The window is read into the RAM output registers when a
// transaction is accepted, and the sum of those taps is registered in the
// result register. The window is held twice, each copy with two read
// ports, giving the four taps per cycle. frame_width and frame_height are
// taken at the first pixel of each frame; write them only while idle.
module cross_stencil_probability_map import csp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel_gray
   input  logic [0:0]           req_tuser,   // [0] req_type
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [10:0] prob_num, rest zero
   output logic                 rsp_tlast,   // last_of_frame
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0]  frame_width_ff,  frame_width_in;
   logic [CFG_W-1:0]  frame_height_ff, frame_height_in;

   // stage 1: window read data sits in the RAM output registers
   logic              s1_v_ff, s1_v_in;
   tap_ctrl_type      s1_ctrl_ff;

   logic              accept;
   logic              has_result;
   tap_ctrl_type      ctrl;
   rd_addr_type       rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_data;
   logic [PIX_W-1:0]  tap_centre, tap_left, tap_right, tap_up;
   logic              load_ok;
   logic [PROB_W-1:0] prob;

   // stage 1 can take a new transaction whenever it empties this cycle
   assign req_tready = !s1_v_ff || load_ok;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_DIM_RESET;
         frame_height_ff <= FRAME_DIM_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   csp_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_tuser[0]),
      .pixel_gray   (req_tdata[PIX_W-1:0]),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .has_result   (has_result),
      .ctrl         (ctrl),
      .rd_addr      (rd_addr),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   // two identical copies of the window: centre/right and left/up
   csp_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_win_cr (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (rd_addr.centre),
      .rd_addr_b (rd_addr.right),
      .rd_data_a (tap_centre),
      .rd_data_b (tap_right)
   );

   csp_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_win_lu (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (rd_addr.left),
      .rd_addr_b (rd_addr.up),
      .rd_data_a (tap_left),
      .rd_data_b (tap_up)
   );

   always_comb begin
      priority if (accept) begin
         s1_v_in = has_result;
      end else if (load_ok) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl;
      end
   end

   csp_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_v_ff),
      .ctrl      (s1_ctrl_ff),
      .centre    (tap_centre),
      .left      (tap_left),
      .right     (tap_right),
      .up        (tap_up),
      .rsp_ready (rsp_tready),
      .load_ok   (load_ok),
      .rsp_valid (rsp_tvalid),
      .prob      (prob),
      .last      (rsp_tlast)
   );

   assign rsp_tdata = {{(16 - PROB_W){1'b0}}, prob};

endmodule
